### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg - shared types and constants for the point to segment distance unit
// Coordinate and intermediate widths, region codes and payload structs.
// ----------------------------------------------------------------------------
package psd_pkg;

   // coordinate format: signed, COORD_WIDTH bits
   localparam int COORD_WIDTH     = 32;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH       = PROD_WIDTH + 1;
   localparam int TARGET_WIDTH    = 2 * SUM_WIDTH;
   localparam int DIST_WIDTH      = COORD_WIDTH + 1;
   localparam int ROOT_WIDTH      = TARGET_WIDTH + 2;
   localparam int STEP_WIDTH      = $clog2(DIST_WIDTH);
   // split of |cross| for squaring in three partial products
   localparam int SPLIT_LO        = (SUM_WIDTH + 1) / 2;
   localparam int SPLIT_HI        = SUM_WIDTH - SPLIT_LO;
   // front to back queue
   localparam int QUEUE_DEPTH     = 8;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;

   typedef enum logic [1:0] {
      REGION_BEYOND_B   = 2'd0,
      REGION_BEFORE_A   = 2'd1,
      REGION_INTERIOR   = 2'd2,
      REGION_DEGENERATE = 2'd3
   } region_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] seg_start_x;
      logic signed [COORD_WIDTH-1:0] seg_start_y;
      logic signed [COORD_WIDTH-1:0] seg_end_x;
      logic signed [COORD_WIDTH-1:0] seg_end_y;
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic [1:0]            nearest_region;
   } rsp_type;

   // one classified job: largest q with q*q*scale <= target
   typedef struct packed {
      logic [TARGET_WIDTH-1:0] target;
      logic [SUM_WIDTH-1:0]    scale;
      region_type              region;
   } job_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic valid;
      logic pop;
   } job_ctl_type;

endpackage

### rtl/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front - classification pipeline
// Five stages: differences, products, sums, region select, target squaring.
// ----------------------------------------------------------------------------
module psd_front
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    job_valid,
   output job_type job
);

   // stage 1: differences
   logic                         v1_ff;
   logic signed [DIFF_WIDTH-1:0] abx_ff, aby_ff, bpx_ff, bpy_ff, apx_ff, apy_ff;
   // stage 2: products
   logic                         v2_ff, degen2_ff;
   logic signed [PROD_WIDTH-1:0] p_abx_bpx_ff, p_aby_bpy_ff, p_abx_apx_ff, p_aby_apy_ff;
   logic signed [PROD_WIDTH-1:0] p_abx_apy_ff, p_aby_apx_ff, p_abx2_ff, p_aby2_ff;
   logic signed [PROD_WIDTH-1:0] p_bpx2_ff, p_bpy2_ff, p_apx2_ff, p_apy2_ff;
   // stage 3: sums
   logic                         v3_ff, degen3_ff;
   logic signed [SUM_WIDTH-1:0]  dot_b_ff, dot_a_ff, cross_ff, len2_ff, lb_ff, la_ff;
   // stage 4: region and magnitudes
   logic                         v4_ff;
   region_type                   region4_ff;
   logic [SUM_WIDTH-1:0]         mag4_ff, lsel4_ff, scale4_ff;
   // stage 5: partial squares of |cross|
   logic                         v5_ff;
   region_type                   region5_ff;
   logic [SUM_WIDTH-1:0]         lsel5_ff, scale5_ff;
   logic [2*SPLIT_HI-1:0]        hh_ff;
   logic [SPLIT_HI+SPLIT_LO-1:0] hl_ff;
   logic [2*SPLIT_LO-1:0]        ll_ff;

   region_type                   region4_in;
   logic [SUM_WIDTH-1:0]         lsel4_in, scale4_in, mag4_in;
   logic [SPLIT_HI-1:0]          mag_hi;
   logic [SPLIT_LO-1:0]          mag_lo;
   logic [TARGET_WIDTH-1:0]      cross_sq;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // stages 1 to 3: exact signed arithmetic
   always_ff @(posedge clock) begin
      abx_ff <= DIFF_WIDTH'(in_req.seg_end_x) - DIFF_WIDTH'(in_req.seg_start_x);
      aby_ff <= DIFF_WIDTH'(in_req.seg_end_y) - DIFF_WIDTH'(in_req.seg_start_y);
      bpx_ff <= DIFF_WIDTH'(in_req.point_x)   - DIFF_WIDTH'(in_req.seg_end_x);
      bpy_ff <= DIFF_WIDTH'(in_req.point_y)   - DIFF_WIDTH'(in_req.seg_end_y);
      apx_ff <= DIFF_WIDTH'(in_req.point_x)   - DIFF_WIDTH'(in_req.seg_start_x);
      apy_ff <= DIFF_WIDTH'(in_req.point_y)   - DIFF_WIDTH'(in_req.seg_start_y);

      degen2_ff    <= (abx_ff == '0) && (aby_ff == '0);
      p_abx_bpx_ff <= PROD_WIDTH'(abx_ff) * PROD_WIDTH'(bpx_ff);
      p_aby_bpy_ff <= PROD_WIDTH'(aby_ff) * PROD_WIDTH'(bpy_ff);
      p_abx_apx_ff <= PROD_WIDTH'(abx_ff) * PROD_WIDTH'(apx_ff);
      p_aby_apy_ff <= PROD_WIDTH'(aby_ff) * PROD_WIDTH'(apy_ff);
      p_abx_apy_ff <= PROD_WIDTH'(abx_ff) * PROD_WIDTH'(apy_ff);
      p_aby_apx_ff <= PROD_WIDTH'(aby_ff) * PROD_WIDTH'(apx_ff);
      p_abx2_ff    <= PROD_WIDTH'(abx_ff) * PROD_WIDTH'(abx_ff);
      p_aby2_ff    <= PROD_WIDTH'(aby_ff) * PROD_WIDTH'(aby_ff);
      p_bpx2_ff    <= PROD_WIDTH'(bpx_ff) * PROD_WIDTH'(bpx_ff);
      p_bpy2_ff    <= PROD_WIDTH'(bpy_ff) * PROD_WIDTH'(bpy_ff);
      p_apx2_ff    <= PROD_WIDTH'(apx_ff) * PROD_WIDTH'(apx_ff);
      p_apy2_ff    <= PROD_WIDTH'(apy_ff) * PROD_WIDTH'(apy_ff);

      degen3_ff <= degen2_ff;
      dot_b_ff  <= SUM_WIDTH'(p_abx_bpx_ff) + SUM_WIDTH'(p_aby_bpy_ff);
      dot_a_ff  <= SUM_WIDTH'(p_abx_apx_ff) + SUM_WIDTH'(p_aby_apy_ff);
      cross_ff  <= SUM_WIDTH'(p_abx_apy_ff) - SUM_WIDTH'(p_aby_apx_ff);
      len2_ff   <= SUM_WIDTH'(p_abx2_ff) + SUM_WIDTH'(p_aby2_ff);
      lb_ff     <= SUM_WIDTH'(p_bpx2_ff) + SUM_WIDTH'(p_bpy2_ff);
      la_ff     <= SUM_WIDTH'(p_apx2_ff) + SUM_WIDTH'(p_apy2_ff);
   end

   // stage 4: classify, pick the length target and scale
   always_comb begin
      mag4_in   = cross_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-cross_ff) : SUM_WIDTH'(cross_ff);
      scale4_in = SUM_WIDTH'(1);
      lsel4_in  = la_ff;
      if (!dot_b_ff[SUM_WIDTH-1] && (dot_b_ff != '0)) begin
         region4_in = REGION_BEYOND_B;
         lsel4_in   = lb_ff;
      end else if (dot_a_ff[SUM_WIDTH-1]) begin
         region4_in = REGION_BEFORE_A;
      end else if (degen3_ff) begin
         region4_in = REGION_DEGENERATE;
      end else begin
         region4_in = REGION_INTERIOR;
         scale4_in  = len2_ff;
      end
   end

   // stage 4 and 5 registers
   assign mag_hi = mag4_ff[SUM_WIDTH-1:SPLIT_LO];
   assign mag_lo = mag4_ff[SPLIT_LO-1:0];

   always_ff @(posedge clock) begin
      region4_ff <= region4_in;
      mag4_ff    <= mag4_in;
      lsel4_ff   <= lsel4_in;
      scale4_ff  <= scale4_in;

      region5_ff <= region4_ff;
      lsel5_ff   <= lsel4_ff;
      scale5_ff  <= scale4_ff;
      hh_ff      <= mag_hi * mag_hi;
      hl_ff      <= mag_hi * mag_lo;
      ll_ff      <= mag_lo * mag_lo;
   end

   // cross squared from the partial squares
   assign cross_sq = (TARGET_WIDTH'(hh_ff) << (2 * SPLIT_LO))
                   + (TARGET_WIDTH'(hl_ff) << (SPLIT_LO + 1))
                   + TARGET_WIDTH'(ll_ff);

   assign job_valid  = v5_ff;
   assign job.region = region5_ff;
   assign job.scale  = scale5_ff;
   assign job.target = (region5_ff == REGION_INTERIOR) ? cross_sq : TARGET_WIDTH'(lsel5_ff);

endmodule

### rtl/psd_fifo.sv
// ----------------------------------------------------------------------------
// psd_fifo - job queue between front and back
// Small register queue; read data is the head entry.
// ----------------------------------------------------------------------------
module psd_fifo
   import psd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  job_type     push_job,
   input  logic        pop,
   output job_ctl_type status,
   output job_type     head_job
);

   job_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + QUEUE_CNT_WIDTH'(push) - QUEUE_CNT_WIDTH'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_job;
   end

   assign head_job     = entry_ff[rd_ptr_ff];
   assign status.valid = (count_ff != '0);
   assign status.pop   = pop;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job queue read while empty");
`endif

endmodule

### rtl/psd_root.sv
// ----------------------------------------------------------------------------
// psd_root - bit-serial scaled square root
// Finds the largest q with q*q*scale <= target, one result bit per cycle.
// ----------------------------------------------------------------------------
module psd_root
   import psd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  job_ctl_type queue_status,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_strobe,
   output rsp_type     rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [ROOT_WIDTH-1:0] rem_ff, rem_in, e_ff, e_in, d_ff, d_in, delta;
   logic [DIST_WIDTH-1:0] q_ff, q_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   region_type            region_ff, region_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  take;

   // trial: cost of setting the current bit is e + d
   assign delta = e_ff + d_ff;
   assign take  = (delta <= rem_ff);

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      e_in      = e_ff;
      d_in      = d_ff;
      q_in      = q_ff;
      step_in   = step_ff;
      region_in = region_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      pop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_status.valid) begin
               pop       = 1'b1;
               rem_in    = ROOT_WIDTH'(head_job.target);
               d_in      = ROOT_WIDTH'(head_job.scale) << (2 * (DIST_WIDTH - 1));
               e_in      = '0;
               q_in      = '0;
               step_in   = STEP_WIDTH'(DIST_WIDTH - 1);
               region_in = head_job.region;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            d_in    = d_ff >> 2;
            step_in = step_ff - 1'b1;
            if (take) begin
               rem_in = rem_ff - delta;
               e_in   = (e_ff >> 1) + d_ff;
               q_in   = q_ff | (DIST_WIDTH'(1) << step_ff);
            end else begin
               e_in   = e_ff >> 1;
            end
            if (step_ff == '0) begin
               strobe_in                 = 1'b1;
               rsp_in.distance           = q_in;
               rsp_in.nearest_region     = region_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      e_ff      <= e_in;
      d_ff      <= d_in;
      q_ff      <= q_in;
      step_ff   <= step_in;
      region_ff <= region_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_RUN))
      else $error("result strobe without a finished root");
`endif

endmodule

### rtl/point_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_unit - shortest distance from a point to a segment
// Front pipeline classifies each item, a queue decouples it from the
// bit-serial root unit that produces the distance.
// ----------------------------------------------------------------------------
//  channel   ports                        transfer
//  request   start, busy, req_payload     start high and busy low at edge
//  response  rsp_strobe, rsp_payload      one cycle per result, no stall
//
//  Front takes one item per cycle until the credit count reaches eight.
//  Back end: a load step plus 33 root steps per item; it takes the next
//  job only after the last result, so the serial root loop sets the rate.
//  Synchronous reset clears control; the queue starts empty.
// ----------------------------------------------------------------------------
module point_segment_distance_unit
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic                       accept;
   logic                       job_valid;
   job_type                    front_job, head_job;
   job_ctl_type                queue_status;
   logic                       pop;
   logic [QUEUE_CNT_WIDTH-1:0] credit_ff, credit_in;

   // credits cover items in the front pipeline plus queued jobs
   assign busy      = (credit_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign accept    = start && !busy;
   assign credit_in = credit_ff + QUEUE_CNT_WIDTH'(accept) - QUEUE_CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_payload),
      .job_valid (job_valid),
      .job       (front_job)
   );

   psd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (front_job),
      .pop      (pop),
      .status   (queue_status),
      .head_job (head_job)
   );

   psd_root u_root (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_payload  (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH))
      else $error("credit count above queue depth");
`endif

endmodule

### tb/psd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psd_checker - distance predictor and result comparator
// Watches request and result transfers, computes the exact floored distance
// and region for every accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module psd_checker
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      pending_count
);

   rsp_type pending_results[$];

   // largest q < 2^33 with q*q*scale <= target
   function automatic logic [32:0] floor_root(logic [255:0] target, logic [255:0] scale);
      logic [32:0]  q;
      logic [32:0]  t;
      logic [255:0] sq;
      q = '0;
      for (int b = 32; b >= 0; b--) begin
         t = q | (33'd1 << b);
         sq = 256'(t) * 256'(t) * scale;
         if (sq <= target) q = t;
      end
      return q;
   endfunction

   function automatic rsp_type predict_distance(req_type r);
      logic signed [127:0] ax, ay, bx, by, px, py;
      logic signed [127:0] abx, aby, bpx, bpy, apx, apy, dot_b, dot_a, cr, len2;
      rsp_type o;
      ax = r.seg_start_x; ay = r.seg_start_y;
      bx = r.seg_end_x;   by = r.seg_end_y;
      px = r.point_x;     py = r.point_y;
      abx = bx - ax; aby = by - ay;
      bpx = px - bx; bpy = py - by;
      apx = px - ax; apy = py - ay;
      dot_b = abx * bpx + aby * bpy;
      dot_a = abx * apx + aby * apy;
      if (dot_b > 0) begin
         o.nearest_region = REGION_BEYOND_B;
         o.distance = floor_root(256'(bpx * bpx + bpy * bpy), 256'd1);
      end else if (dot_a < 0) begin
         o.nearest_region = REGION_BEFORE_A;
         o.distance = floor_root(256'(apx * apx + apy * apy), 256'd1);
      end else if (abx == 0 && aby == 0) begin
         o.nearest_region = REGION_DEGENERATE;
         o.distance = floor_root(256'(apx * apx + apy * apy), 256'd1);
      end else begin
         cr = abx * apy - aby * apx;
         if (cr < 0) cr = -cr;
         len2 = abx * abx + aby * aby;
         o.nearest_region = REGION_INTERIOR;
         o.distance = floor_root(256'(cr) * 256'(cr), 256'(len2));
      end
      return o;
   endfunction

   // queue expectations on request transfers, compare on result strobes
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         if (start && !busy) begin
            pending_results.insert(pending_results.size(), predict_distance(req_payload));
         end
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result dist=%h region=%0d", $time,
                        rsp_payload.distance, rsp_payload.nearest_region);
               error_count <= error_count + 1;
            end else begin
               exp_rsp = pending_results.pop_front();
               if (exp_rsp.distance !== rsp_payload.distance ||
                   exp_rsp.nearest_region !== rsp_payload.nearest_region) begin
                  $display("%0t: mismatch expected dist=%h region=%0d actual dist=%h region=%0d",
                           $time, exp_rsp.distance, exp_rsp.nearest_region,
                           rsp_payload.distance, rsp_payload.nearest_region);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= pending_results.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the point to segment distance unit
// Directed corner cases then random segments and points, with random
// sender gaps, checked transfer by transfer by the checker module.
// ----------------------------------------------------------------------------
module tb;
   import psd_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      error_count;
   int      pending_count;
   int      idle_cycles;
   int      gap_percent;

   point_segment_distance_unit DUT (.*);

   psd_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: cycles with no transfer in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = 32'($signed($urandom_range(0, 8191)) - 4096) <<< 16;
         2: v = 32'($signed($urandom_range(0, 2000)) - 1000);
         3: v = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
         default: v = 32'($signed($urandom_range(0, 65535)) - 32768) <<< 8;
      endcase
      return v;
   endfunction

   // drive one request and hold it until it is taken
   task automatic send_request(req_type r);
      while ($urandom_range(0, 99) < gap_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      req_type r;
      r.seg_start_x = rand_coord(); r.seg_start_y = rand_coord();
      r.seg_end_x   = rand_coord(); r.seg_end_y   = rand_coord();
      r.point_x     = rand_coord(); r.point_y     = rand_coord();
      case ($urandom_range(0, 9))
         0: begin r.seg_end_x = r.seg_start_x; r.seg_end_y = r.seg_start_y; end
         1: begin r.point_x = r.seg_end_x; r.point_y = r.seg_end_y; end
         2: begin r.point_x = r.seg_start_x; r.point_y = r.seg_start_y; end
         default: ;
      endcase
      send_request(r);
   endtask

   localparam logic [31:0] MAXV = 32'h7fffffff;
   localparam logic [31:0] MINV = 32'h80000000;
   localparam logic [31:0] ONE  = 32'h00010000;

   initial begin
      req_type r;
      start = 1'b0;
      req_payload = '0;
      reset = 1'b1;
      gap_percent = 13;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: beyond B, before A, interior, degenerate, extremes
      r = '{0, 0, 10*ONE, 0, 20*ONE, 3*ONE};           send_request(r);
      r = '{0, 0, 10*ONE, 0, -5*ONE, 4*ONE};           send_request(r);
      r = '{0, 0, 10*ONE, 0, 5*ONE, 7*ONE};            send_request(r);
      r = '{ONE, ONE, ONE, ONE, 4*ONE, 5*ONE};         send_request(r);
      r = '{0, 0, 0, 0, 0, 0};                         send_request(r);
      r = '{MINV, MINV, MINV, MINV, MAXV, MAXV};       send_request(r);
      r = '{MAXV, MAXV, MAXV, MAXV, MINV, MINV};       send_request(r);
      r = '{MINV, MINV, MAXV, MAXV, MAXV, MINV};       send_request(r);
      r = '{MINV, MAXV, MAXV, MINV, MINV, MINV};       send_request(r);
      r = '{MINV, 0, MAXV, 0, 0, MAXV};                send_request(r);
      r = '{MINV, MINV, MAXV, MAXV, MINV, MINV};       send_request(r);
      r = '{MINV, MINV, MAXV, MAXV, MAXV, MAXV};       send_request(r);
      r = '{0, 0, 4*ONE, 4*ONE, 4*ONE, 0};             send_request(r);
      r = '{0, 0, 0, 10*ONE, 0, 5*ONE};                send_request(r);
      r = '{32'hffffffff, 1, 1, 32'hffffffff, 32'h12345678, 32'hedcba987};
      send_request(r);

      // random phases: few sender gaps, then many, then none
      repeat (630) send_random();
      gap_percent = 73;
      repeat (630) send_random();
      gap_percent = 0;
      repeat (640) send_random();
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
